>>> sv/b32d_pkg.sv
// Package for the base32 stream decoder: beat types, error codes, message state
// and the character-to-symbol lookup.
// Depends on nothing; used by every module of the decoder.
package b32d_pkg;

    localparam logic [1:0] ERR_NONE     = 2'd0;
    localparam logic [1:0] ERR_CHAR     = 2'd1;
    localparam logic [1:0] ERR_LENGTH   = 2'd2;
    localparam logic [1:0] ERR_LEFTOVER = 2'd3;

    localparam logic [7:0] PAD_CHAR = 8'h3D;

    typedef struct packed {
        logic [7:0] char_in;
        logic       end_of_message;
    } in_beat_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       byte_valid;
        logic       message_done;
        logic [1:0] error_code;
    } out_beat_t;

    typedef struct packed {
        logic [2:0] char_position;
        logic [7:0] partial_byte;
        logic       pad_seen;
        logic       any_data_seen;
        logic [2:0] total_count_mod8;
        logic [1:0] sticky_error;
    } msg_state_t;

    typedef struct packed {
        logic       valid;
        logic [4:0] value;
    } symbol_t;

    function automatic symbol_t decode_symbol(input logic [7:0] ch);
        symbol_t sym;
        logic [7:0] diff;
        sym  = '0;
        diff = '0;
        if (ch >= 8'h41 && ch <= 8'h5A) begin
            diff      = ch - 8'h41;
            sym.valid = 1'b1;
            sym.value = diff[4:0];
        end else if (ch >= 8'h61 && ch <= 8'h7A) begin
            diff      = ch - 8'h61;
            sym.valid = 1'b1;
            sym.value = diff[4:0];
        end else if (ch >= 8'h32 && ch <= 8'h37) begin
            diff      = ch - 8'h32 + 8'd26;
            sym.valid = 1'b1;
            sym.value = diff[4:0];
        end
        return sym;
    endfunction

endpackage

>>> sv/b32d_step.sv
// Per-character decode step: symbol lookup, bit packing, error tracking and the
// end-of-message checks. Purely combinational; depends on b32d_pkg.
module b32d_step (
    input  b32d_pkg::msg_state_t state,
    input  logic                 strict_length,
    input  b32d_pkg::in_beat_t   beat,
    output b32d_pkg::msg_state_t state_next,
    output b32d_pkg::out_beat_t  result,
    output logic                 has_result
);

    b32d_pkg::symbol_t    sym;
    b32d_pkg::msg_state_t upd;
    logic [7:0]           byte_val;
    logic                 have_byte;
    logic                 len_ok;
    logic [1:0]           err;
    logic [4:0]           v;

    always_comb begin
        sym       = b32d_pkg::decode_symbol(beat.char_in);
        v         = sym.value;
        upd       = state;
        byte_val  = '0;
        have_byte = 1'b0;
        upd.total_count_mod8 = state.total_count_mod8 + 3'd1;

        if (state.sticky_error == b32d_pkg::ERR_NONE) begin
            if (beat.char_in == b32d_pkg::PAD_CHAR) begin
                upd.pad_seen = 1'b1;
            end else if (state.pad_seen || !sym.valid) begin
                upd.sticky_error = b32d_pkg::ERR_CHAR;
            end else begin
                unique case (state.char_position)
                    3'd0: begin
                        upd.partial_byte = {v, 3'b000};
                    end
                    3'd1: begin
                        byte_val         = state.partial_byte | {5'b0, v[4:2]};
                        have_byte        = 1'b1;
                        upd.partial_byte = {v[1:0], 6'b0};
                    end
                    3'd2: begin
                        upd.partial_byte = state.partial_byte | {2'b0, v, 1'b0};
                    end
                    3'd3: begin
                        byte_val         = state.partial_byte | {7'b0, v[4]};
                        have_byte        = 1'b1;
                        upd.partial_byte = {v[3:0], 4'b0};
                    end
                    3'd4: begin
                        byte_val         = state.partial_byte | {4'b0, v[4:1]};
                        have_byte        = 1'b1;
                        upd.partial_byte = {v[0], 7'b0};
                    end
                    3'd5: begin
                        upd.partial_byte = state.partial_byte | {1'b0, v, 2'b0};
                    end
                    3'd6: begin
                        byte_val         = state.partial_byte | {6'b0, v[4:3]};
                        have_byte        = 1'b1;
                        upd.partial_byte = {v[2:0], 5'b0};
                    end
                    default: begin
                        byte_val         = state.partial_byte | {3'b0, v};
                        have_byte        = 1'b1;
                        upd.partial_byte = '0;
                    end
                endcase
                upd.char_position = state.char_position + 3'd1;
                upd.any_data_seen = 1'b1;
            end
        end

        case (upd.char_position) inside
            3'd0, 3'd2, 3'd4, 3'd5, 3'd7: len_ok = upd.any_data_seen;
            default:                      len_ok = 1'b0;
        endcase

        err = upd.sticky_error;
        if (err == b32d_pkg::ERR_NONE) begin
            if (!len_ok || (strict_length && upd.total_count_mod8 != 3'd0)) begin
                err = b32d_pkg::ERR_LENGTH;
            end else if (upd.partial_byte != 8'd0) begin
                err = b32d_pkg::ERR_LEFTOVER;
            end
        end

        result = '0;
        if (beat.end_of_message) begin
            has_result          = 1'b1;
            state_next          = '0;
            result.message_done = 1'b1;
            result.error_code   = err;
            if (err == b32d_pkg::ERR_NONE && have_byte) begin
                result.byte_valid = 1'b1;
                result.data_byte  = byte_val;
            end
        end else begin
            state_next = upd;
            has_result = have_byte && (upd.sticky_error == b32d_pkg::ERR_NONE);
            if (has_result) begin
                result.byte_valid = 1'b1;
                result.data_byte  = byte_val;
            end
        end
    end

endmodule

>>> sv/base32_stream_decoder.sv
// Top level of the base32 stream decoder: input register, decode step and
// result register. Depends on b32d_pkg and b32d_step.
//
// One base32 character enters per s_ beat; end_of_message marks the last one.
// A result beat leaves on m_ when a byte completes, and always for the last
// character, carrying message_done and the error code for the whole message.
// A character accepted on s_ is held in the input register and decoded out of
// it; its result is registered in the result register once that register is
// free to take it. A character that yields no result retires from the input
// register without touching m_.
// Throughput is one character per cycle while the receiver does not stall,
// set by the combinational decode step between the input and result registers.
// When the receiver stalls, the result register holds its beat and the input
// register holds one more character; s_ready then drops only if that
// character would produce a result. Synchronous reset clears the valid bits of
// both registers, the message state and strict_length; cfg_we sets strict_length.
module base32_stream_decoder (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  b32d_pkg::in_beat_t  s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output b32d_pkg::out_beat_t m_data,
    input  logic                cfg_we,
    input  logic                cfg_wdata
);

    logic                 in_valid_reg;
    b32d_pkg::in_beat_t   in_beat_reg;
    logic                 out_valid_reg;
    b32d_pkg::out_beat_t  out_beat_reg;
    b32d_pkg::msg_state_t state_reg;
    b32d_pkg::msg_state_t state_next;
    logic                 strict_reg;
    b32d_pkg::out_beat_t  step_result;
    logic                 step_has_result;
    logic                 out_free;
    logic                 advance;

    b32d_step u_step (
        .state         (state_reg),
        .strict_length (strict_reg),
        .beat          (in_beat_reg),
        .state_next    (state_next),
        .result        (step_result),
        .has_result    (step_has_result)
    );

    assign out_free = !out_valid_reg || m_ready;
    assign advance  = in_valid_reg && (out_free || !step_has_result);
    assign s_ready  = !in_valid_reg || advance;
    assign m_valid  = out_valid_reg;
    assign m_data   = out_beat_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= '0;
            strict_reg    <= 1'b0;
        end else begin
            if (cfg_we) begin
                strict_reg <= cfg_wdata;
            end
            if (s_valid && s_ready) begin
                in_valid_reg <= 1'b1;
            end else if (advance) begin
                in_valid_reg <= 1'b0;
            end
            if (advance) begin
                state_reg <= state_next;
            end
            if (advance && step_has_result) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_beat_reg <= s_data;
        end
        if (advance && step_has_result) begin
            out_beat_reg <= step_result;
        end
    end

endmodule

>>> sv/b32d_checker.sv
// Port-level checks for the base32 stream decoder, bound to the top level.
// Depends on b32d_pkg and base32_stream_decoder.
module b32d_checker (
    input logic                aclk,
    input logic                aresetn,
    input logic                m_valid,
    input logic                m_ready,
    input b32d_pkg::out_beat_t m_data
);

    property p_out_hold;
        @(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data);
    endproperty
    a_out_hold: assert property (p_out_hold) else $error("result beat changed under stall");

    property p_no_empty_result;
        @(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_data.byte_valid || m_data.message_done);
    endproperty
    a_no_empty_result: assert property (p_no_empty_result)
        else $error("result beat carries neither a byte nor an end of message");

    property p_error_only_at_end;
        @(posedge aclk) disable iff (!aresetn)
        m_valid && !m_data.message_done |-> m_data.error_code == b32d_pkg::ERR_NONE;
    endproperty
    a_error_only_at_end: assert property (p_error_only_at_end)
        else $error("error code reported before end of message");

    property p_no_byte_on_error;
        @(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.error_code != b32d_pkg::ERR_NONE |->
            !m_data.byte_valid && m_data.data_byte == 8'd0;
    endproperty
    a_no_byte_on_error: assert property (p_no_byte_on_error)
        else $error("byte delivered with a failing message result");

endmodule

bind base32_stream_decoder b32d_checker u_b32d_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);
